FILE: hdl/kdar_pkg.sv
// Shared types and constants for the key debounce and auto-repeat block.
// Used by kdar_lane, kdar_merge and key_debounce_auto_repeat. No dependencies.
`timescale 1ns / 1ps

package kdar_pkg;

    localparam int KEY_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int DEB_W     = 4;
    localparam int CNT_W     = 8;

    localparam logic [DEB_W-1:0] DEB_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_START_TICKS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INITIAL_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_STEP_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FLOOR_TICKS   = 3'd4;

    localparam logic [DEB_W-1:0] RST_DEBOUNCE_SAMPLES     = 4'd2;
    localparam logic [CNT_W-1:0] RST_HOLD_START_TICKS     = 8'd20;
    localparam logic [CNT_W-1:0] RST_REPEAT_INITIAL_TICKS = 8'd25;
    localparam logic [CNT_W-1:0] RST_REPEAT_STEP_TICKS    = 8'd5;
    localparam logic [CNT_W-1:0] RST_REPEAT_FLOOR_TICKS   = 8'd1;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_samples;
        logic [CNT_W-1:0] hold_start_ticks;
        logic [CNT_W-1:0] repeat_initial_ticks;
        logic [CNT_W-1:0] repeat_step_ticks;
        logic [CNT_W-1:0] repeat_floor_ticks;
    } kdar_cfg_t;

endpackage

FILE: hdl/kdar_lane.sv
// One key lane: debounce filter, hold counter and accelerating repeat timer.
// Depends on kdar_pkg for the configuration struct and counter widths.
`timescale 1ns / 1ps

module kdar_lane
    import kdar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      sample,
    input  logic      enabled,
    input  kdar_cfg_t cfg,
    output logic      key_event
);

    logic             conf_reg,   conf_next;
    logic [DEB_W-1:0] deb_reg,    deb_next;
    logic [CNT_W-1:0] hold_reg,   hold_next;
    logic [CNT_W-1:0] given_reg,  given_next;
    logic [CNT_W-1:0] cd_reg,     cd_next;
    logic             active_reg, active_next;

    logic [2*CNT_W-1:0] cut;
    logic [CNT_W-1:0]   interval;
    logic [DEB_W-1:0]   deb_inc;
    logic [CNT_W-1:0]   hold_inc;

    assign cut      = (2*CNT_W)'(given_reg) * (2*CNT_W)'(cfg.repeat_step_ticks);
    assign interval = ((2*CNT_W)'(cfg.repeat_initial_ticks) > cut)
                    ? (cfg.repeat_initial_ticks - cut[CNT_W-1:0])
                    : cfg.repeat_floor_ticks;
    assign deb_inc  = (deb_reg == DEB_MAX) ? deb_reg : deb_reg + 1'b1;
    assign hold_inc = (hold_reg == CNT_MAX) ? hold_reg : hold_reg + 1'b1;

    always_comb
    begin
        conf_next   = conf_reg;
        deb_next    = deb_reg;
        hold_next   = hold_reg;
        given_next  = given_reg;
        cd_next     = cd_reg;
        active_next = active_reg;
        key_event   = 1'b0;
        if (sample != conf_reg)
        begin
            if (deb_inc >= cfg.debounce_samples)
            begin
                deb_next  = '0;
                conf_next = sample;
                if (sample)
                begin
                    key_event   = !active_reg;
                    active_next = 1'b0;
                end
            end
            else
            begin
                deb_next = deb_inc;
            end
        end
        else
        begin
            deb_next = '0;
            if (enabled && !conf_reg)
            begin
                hold_next = hold_inc;
                if (hold_inc >= cfg.hold_start_ticks)
                begin
                    active_next = 1'b1;
                    if (cd_reg == '0)
                    begin
                        key_event  = 1'b1;
                        cd_next    = interval;
                        given_next = (given_reg == CNT_MAX) ? given_reg : given_reg + 1'b1;
                    end
                    else
                    begin
                        cd_next = cd_reg - 1'b1;
                    end
                end
            end
            else
            begin
                hold_next  = '0;
                given_next = '0;
                cd_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_reg   <= 1'b1;
            deb_reg    <= '0;
            hold_reg   <= '0;
            given_reg  <= '0;
            cd_reg     <= '0;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            conf_reg   <= conf_next;
            deb_reg    <= deb_next;
            hold_reg   <= hold_next;
            given_reg  <= given_next;
            cd_reg     <= cd_next;
            active_reg <= active_next;
        end
    end

endmodule

FILE: hdl/kdar_merge.sv
// Merge stage: gathers lane event bits into one result, with output register and skid.
// Depends on kdar_pkg for the key field width.
`timescale 1ns / 1ps

module kdar_merge
    import kdar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [KEY_W-1:0] lane_events,
    output logic             full,
    output logic             event_valid,
    input  logic             event_stall,
    output logic [KEY_W-1:0] key_events
);

    logic             out_valid_reg,  out_valid_next;
    logic [KEY_W-1:0] out_data_reg,   out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [KEY_W-1:0] skid_data_reg,  skid_data_next;
    logic             take;

    assign take = out_valid_reg && !event_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = lane_events;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = lane_events;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full        = skid_valid_reg;
    assign event_valid = out_valid_reg;
    assign key_events  = out_data_reg;

endmodule

FILE: hdl/key_debounce_auto_repeat.sv
// Top level of the key debounce and auto-repeat block: config registers, lanes, merge.
// Depends on kdar_pkg, kdar_lane and kdar_merge.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   tick     | tick_valid, tick_stall, key_levels,       | in
//            | repeat_enable                             |
//   event    | event_valid, event_stall, key_events      | out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One tick transfer per cycle unless stalled; the result enters the output or skid register.
// All key lanes update in parallel in the transfer cycle; the merge stage registers the bits.
// Reset clears every lane to released and idle and loads the default register values.
// tick_stall rises only when both the output register and the skid entry hold results.
// cfg_ready is always high.
`timescale 1ns / 1ps

module key_debounce_auto_repeat
    import kdar_pkg::*;
#(
    parameter int NUM_KEYS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_valid,
    output logic                 tick_stall,
    input  logic [KEY_W-1:0]     key_levels,
    input  logic [KEY_W-1:0]     repeat_enable,
    output logic                 event_valid,
    input  logic                 event_stall,
    output logic [KEY_W-1:0]     key_events,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    kdar_cfg_t        cfg_reg;
    logic             advance;
    logic             merge_full;
    logic [KEY_W-1:0] lane_events;

    assign cfg_ready  = 1'b1;
    assign advance    = tick_valid && !merge_full;
    assign tick_stall = merge_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_samples     <= RST_DEBOUNCE_SAMPLES;
            cfg_reg.hold_start_ticks     <= RST_HOLD_START_TICKS;
            cfg_reg.repeat_initial_ticks <= RST_REPEAT_INITIAL_TICKS;
            cfg_reg.repeat_step_ticks    <= RST_REPEAT_STEP_TICKS;
            cfg_reg.repeat_floor_ticks   <= RST_REPEAT_FLOOR_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE_SAMPLES:     cfg_reg.debounce_samples <= cfg_data[DEB_W-1:0];
                REG_HOLD_START_TICKS:     cfg_reg.hold_start_ticks <= cfg_data;
                REG_REPEAT_INITIAL_TICKS: cfg_reg.repeat_initial_ticks <= cfg_data;
                REG_REPEAT_STEP_TICKS:    cfg_reg.repeat_step_ticks <= cfg_data;
                REG_REPEAT_FLOOR_TICKS:   cfg_reg.repeat_floor_ticks <= cfg_data;
                default:                  ;
            endcase
        end
    end

    for (genvar k = 0; k < KEY_W; k++)
    begin : g_lane
        if (k < NUM_KEYS)
        begin : g_on
            kdar_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .sample    (key_levels[k]),
                .enabled   (repeat_enable[k]),
                .cfg       (cfg_reg),
                .key_event (lane_events[k])
            );
        end
        else
        begin : g_off
            assign lane_events[k] = 1'b0;
        end
    end

    kdar_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (advance),
        .lane_events (lane_events),
        .full        (merge_full),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .key_events  (key_events)
    );

`ifndef ASSERT_OFF
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> event_valid)
        else $error("tick channel stalled with no result pending");

    a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && !tick_stall) |=> event_valid)
        else $error("tick transfer produced no result");

    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!event_valid) |=> !tick_stall)
        else $error("tick channel stalled after output drained");
`endif

endmodule
